### hw/rtl/psfp_pkg.sv
// ----------------------------------------------------------------------------
// Particulate sensor frame parser package
// Shared constants, operation codes and queue entry type.
// ----------------------------------------------------------------------------
package psfp_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h4D;

    // Frame offsets, five bits cover a 32-byte frame.
    localparam logic [4:0] POS_HUNT   = 5'd0;
    localparam logic [4:0] POS_HDR2   = 5'd1;
    localparam logic [4:0] SUM_END    = 5'd30;
    localparam logic [4:0] FRAME_LAST = 5'd31;
    localparam logic [4:0] POS_PM1    = 5'd11;
    localparam logic [4:0] POS_PM25   = 5'd13;
    localparam logic [4:0] POS_PM10   = 5'd15;
    localparam logic [4:0] POS_TEMP   = 5'd25;
    localparam logic [4:0] POS_HUMID  = 5'd27;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_START = 2'd0,   // first header byte: restart the sum
        OP_BODY  = 2'd1,   // ordinary frame byte: sum and capture
        OP_CHECK = 2'd2    // last byte: compare checksum and emit
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] pos;
        logic [7:0] data;
    } t_qent;

    typedef struct packed {
        logic [15:0] humidity_tenths;
        logic [15:0] temperature_tenths;
        logic [15:0] pm10;
        logic [15:0] pm2_5;
        logic [15:0] pm1_0;
    } t_result;

endpackage

### hw/rtl/psfp_front.sv
// ----------------------------------------------------------------------------
// Frame parser front end
// Tracks the frame offset, hunts for the header and classifies each byte.
// ----------------------------------------------------------------------------
module psfp_front import psfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_qent      o_entry
);

    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic       accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        n_pos         = r_pos;
        o_push        = 1'b0;
        o_entry.op    = OP_BODY;
        o_entry.pos   = r_pos;
        o_entry.data  = i_byte;
        if (accept) begin
            if (r_pos == POS_HUNT) begin
                if (i_byte == HDR_FIRST) begin
                    o_push     = 1'b1;
                    o_entry.op = OP_START;
                    n_pos      = POS_HDR2;
                end
            end else if (r_pos == POS_HDR2) begin
                if (i_byte == HDR_SECOND) begin
                    o_push = 1'b1;
                    n_pos  = r_pos + 5'd1;
                end else if (i_byte == HDR_FIRST) begin
                    o_push     = 1'b1;
                    o_entry.op = OP_START;
                    n_pos      = POS_HDR2;
                end else begin
                    n_pos = POS_HUNT;
                end
            end else if (r_pos == FRAME_LAST) begin
                o_push     = 1'b1;
                o_entry.op = OP_CHECK;
                n_pos      = POS_HUNT;
            end else begin
                o_push = 1'b1;
                n_pos  = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

### hw/rtl/psfp_queue.sv
// ----------------------------------------------------------------------------
// Frame parser operation queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module psfp_queue import psfp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_entry,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_qent o_entry
);

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hw/rtl/psfp_back.sv
// ----------------------------------------------------------------------------
// Frame parser back end
// Keeps the running sum and captured words, checks the checksum, holds result.
// ----------------------------------------------------------------------------
module psfp_back import psfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_qent   i_entry,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [15:0] r_sum;
    logic [7:0]  r_hold;
    t_result     r_cap;
    t_result     r_out;
    logic        r_out_valid;
    logic        out_free;
    logic        load;
    logic [15:0] word;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_q_valid && ((i_entry.op != OP_CHECK) || out_free);
    assign word     = {r_hold, i_entry.data};
    assign load     = o_pop && (i_entry.op == OP_CHECK) && (word == r_sum);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_entry.op)
                OP_START: begin
                    r_sum <= {8'd0, i_entry.data};
                end
                OP_BODY: begin
                    if (i_entry.pos < SUM_END) begin
                        r_sum <= r_sum + {8'd0, i_entry.data};
                    end
                    if (!i_entry.pos[0]) begin
                        r_hold <= i_entry.data;
                    end else begin
                        case (i_entry.pos)
                            POS_PM1:   r_cap.pm1_0              <= word;
                            POS_PM25:  r_cap.pm2_5              <= word;
                            POS_PM10:  r_cap.pm10               <= word;
                            POS_TEMP:  r_cap.temperature_tenths <= word;
                            POS_HUMID: r_cap.humidity_tenths    <= word;
                            default:   r_cap                    <= r_cap;
                        endcase
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
        if (load) begin
            r_out <= r_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

### hw/rtl/particulate_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// Particulate sensor frame parser
// Finds 32-byte sensor frames in a received byte stream and reports readings.
// ----------------------------------------------------------------------------
// The block takes one received serial byte per beat on the slave side and
// accepts a byte in every clock cycle while its internal queue has room, so
// the sustained rate is one byte per cycle. It hunts for the header bytes
// 0x42 0x4D, then counts through the 32-byte frame, summing bytes 0 to 29
// modulo 65536 and capturing the big-endian words at offsets 10, 12, 14, 24
// and 26. When the last byte arrives the trailing checksum is compared with
// the sum: on a match one result beat leaves on the master side, carrying
// PM1.0, PM2.5, PM10 and raw temperature and humidity in tenths; on a
// mismatch the frame is dropped silently and hunting resumes with the next
// byte. Header-like bytes inside a frame are plain data. A front end tracks
// the frame offset and classifies each byte, a four-entry queue decouples it
// from the back end, which does the summing, capturing and checking. When the
// queue holds nothing older, the last byte of a frame is registered in the
// queue and then its result in an output register, where it is held, so
// bytes keep flowing while a result waits to be taken; only a second result
// that finds the output register still full stalls the back end, and the
// input then stalls once the queue fills.
// ----------------------------------------------------------------------------
module particulate_sensor_frame_parser import psfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // [15:0] pm1_0, [31:16] pm2_5,
                                        // [47:32] pm10, [63:48] temperature_tenths,
                                        // [79:64] humidity_tenths
);

    logic    q_full;
    logic    q_push;
    t_qent   q_in;
    logic    q_pop;
    logic    q_valid;
    t_qent   q_out;
    t_result result;

    psfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_q_full(q_full),
        .o_push  (q_push),
        .o_entry (q_in)
    );

    psfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    psfp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_entry  (q_out),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // The result struct is declared highest field first, so it packs with
    // PM1.0 in the lowest bits.
    assign m_axis_tdata = result;

endmodule

### sim/psfp_reading_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor reading checker
// Watches the byte and result channels of the frame parser. It tracks frames
// in its own parser state, queues the readings that valid frames should give,
// and compares every result beat field by field with the oldest of them.
// ----------------------------------------------------------------------------
module psfp_reading_checker import psfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [79:0] i_out_data,
    output int          o_pending,
    output int          o_fail_count
);

    // Own copy of the parser state.
    logic [4:0]  frame_pos;
    logic [15:0] frame_sum;
    logic [7:0]  word_high;
    t_result     captured;

    t_result     reading_q [$];
    int          mismatch_total = 0;

    t_result     want;
    logic [79:0] want_bits;
    bit          beat_bad;

    string field_name [5] = '{"pm1_0", "pm2_5", "pm10",
                              "temperature_tenths", "humidity_tenths"};

    // Advances the frame state by one received byte and queues a reading when
    // the checksum of a complete frame matches.
    task automatic parse_rx_byte(input logic [7:0] rx);
        logic [15:0] word;
        word = {word_high, rx};
        if (frame_pos == POS_HUNT) begin
            if (rx == HDR_FIRST) begin
                frame_sum = {8'h00, HDR_FIRST};
                frame_pos = POS_HDR2;
            end
        end else if (frame_pos == POS_HDR2) begin
            if (rx == HDR_SECOND) begin
                frame_sum = frame_sum + {8'h00, rx};
                frame_pos = POS_HDR2 + 5'd1;
            end else if (rx == HDR_FIRST) begin
                // A repeated first header byte starts the frame afresh.
                frame_sum = {8'h00, HDR_FIRST};
            end else begin
                frame_pos = POS_HUNT;
            end
        end else if (frame_pos == FRAME_LAST) begin
            frame_pos = POS_HUNT;
            if (word == frame_sum)
                reading_q.push_back(captured);
        end else begin
            if (frame_pos < SUM_END)
                frame_sum = frame_sum + {8'h00, rx};
            if (!frame_pos[0]) begin
                word_high = rx;
            end else begin
                case (frame_pos)
                    POS_PM1:   captured.pm1_0              = word;
                    POS_PM25:  captured.pm2_5              = word;
                    POS_PM10:  captured.pm10               = word;
                    POS_TEMP:  captured.temperature_tenths = word;
                    POS_HUMID: captured.humidity_tenths    = word;
                    default: ;
                endcase
            end
            frame_pos = frame_pos + 5'd1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos = POS_HUNT;
            frame_sum = '0;
            word_high = '0;
            captured  = '0;
            reading_q.delete();
        end else begin
            // A result never leaves in the cycle its last byte enters, so the
            // result side is handled first.
            if (i_out_valid && i_out_ready) begin
                if (reading_q.size() == 0) begin
                    $error("result beat with no reading expected: %h", i_out_data);
                    mismatch_total++;
                end else begin
                    want      = reading_q.pop_front();
                    want_bits = want;
                    beat_bad  = 1'b0;
                    for (int k = 0; k < 5; k++) begin
                        if (i_out_data[16*k +: 16] !== want_bits[16*k +: 16]) begin
                            $error("%s expected %0d got %0d", field_name[k],
                                   want_bits[16*k +: 16], i_out_data[16*k +: 16]);
                            beat_bad = 1'b1;
                        end
                    end
                    if (beat_bad)
                        mismatch_total++;
                end
            end
            if (i_in_valid && i_in_ready)
                parse_rx_byte(i_in_data);
        end
        o_pending    <= reading_q.size();
        o_fail_count <= mismatch_total;
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser testbench
// Feeds sensor frames, broken frames and line noise to the parser in bursts,
// stalls the result side on its own pattern and reports the verdict of the
// reading checker.
// ----------------------------------------------------------------------------
module tb_top import psfp_pkg::*;;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 12;
    localparam int FRAME_ITEMS = 1950;
    localparam int TAIL_CYCLES = 10;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;    // [15:0] pm1_0, [31:16] pm2_5, [47:32] pm10,
                                  // [63:48] temperature_tenths, [79:64] humidity_tenths

    int          pending;
    int          fail_count;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          ready_hold  = 0;
    int          frame_bytes = 0;
    logic [7:0]  tx_bytes [$];

    particulate_sensor_frame_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    psfp_reading_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The result side holds a level for a random stretch; now and then a
    // stall is long enough to back up the output register and the queue.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            ready_hold = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 90)
                                                       : $urandom_range(0, 12);
        end
    end

    // Reading words lean towards the extremes and header-like patterns.
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {HDR_FIRST, HDR_SECOND};
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_result rand_reading();
        t_result r;
        r.pm1_0              = rand_word();
        r.pm2_5              = rand_word();
        r.pm10               = rand_word();
        r.temperature_tenths = rand_word();
        r.humidity_tenths    = rand_word();
        return r;
    endfunction

    // A negative fill asks for random filler bytes, header bytes among them.
    function automatic logic [7:0] fill_byte(input int fill);
        logic [7:0] pick [4];
        pick = '{HDR_FIRST, HDR_SECOND, 8'h00, 8'hFF};
        if (fill >= 0)
            return fill[7:0];
        if ($urandom_range(0, 7) == 0)
            return pick[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Queues one 32-byte frame carrying the given reading; a bad sum has one
    // bit of the checksum word flipped.
    task automatic make_frame(input t_result r, input bit bad_sum, input int fill);
        logic [7:0]  f [32];
        logic [15:0] sum;
        f[0] = HDR_FIRST;
        f[1] = HDR_SECOND;
        for (int k = 2; k < 30; k++)
            f[k] = fill_byte(fill);
        {f[10], f[11]} = r.pm1_0;
        {f[12], f[13]} = r.pm2_5;
        {f[14], f[15]} = r.pm10;
        {f[24], f[25]} = r.temperature_tenths;
        {f[26], f[27]} = r.humidity_tenths;
        sum = '0;
        for (int k = 0; k < 30; k++)
            sum = sum + {8'h00, f[k]};
        if (bad_sum)
            sum = sum ^ (16'h0001 << $urandom_range(0, 15));
        {f[30], f[31]} = sum;
        for (int k = 0; k < 32; k++)
            tx_bytes.push_back(f[k]);
    endtask

    // One beat on the byte side. Bursts of random length are separated by
    // random gaps, some of them empty so that stretches run without idling.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        burst_left--;
        frame_bytes++;
    endtask

    task automatic send_queued();
        while (tx_bytes.size() > 0)
            send_byte(tx_bytes.pop_front());
    endtask

    // Holds the byte side idle until every queued reading has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_result r;
        int      pick;
        int      cut;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Noise while hunting, including a stray second header byte.
        tx_bytes = '{8'h00, 8'hFF, HDR_SECOND};
        // A first header byte followed by something other than the second.
        tx_bytes.push_back(HDR_FIRST);
        tx_bytes.push_back(8'h00);
        // A doubled first header byte ahead of an all-zero reading.
        tx_bytes.push_back(HDR_FIRST);
        r = '0;
        make_frame(r, 1'b0, 0);
        // All readings and filler at their maximum.
        r = '1;
        make_frame(r, 1'b0, 255);
        // A checksum mismatch, then a good frame straight after it.
        make_frame(rand_reading(), 1'b1, -1);
        make_frame(rand_reading(), 1'b0, -1);
        // Header-like bytes throughout the body of a frame.
        r = {5{HDR_FIRST, HDR_SECOND}};
        make_frame(r, 1'b0, int'(HDR_FIRST));
        send_queued();
        wait_drained();

        // Mostly well-formed frames with random content; the rest are bad
        // checksums, truncated frames, line noise and lone header bytes.
        while (frame_bytes < FRAME_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                make_frame(rand_reading(), 1'b0, -1);
            end else if (pick < 17) begin
                make_frame(rand_reading(), 1'b1, -1);
            end else if (pick == 17) begin
                make_frame(rand_reading(), 1'b0, -1);
                cut = $urandom_range(2, 31);
                while (tx_bytes.size() > cut)
                    void'(tx_bytes.pop_back());
            end else if (pick == 18) begin
                repeat ($urandom_range(1, 6))
                    tx_bytes.push_back(fill_byte(-1));
            end else begin
                tx_bytes.push_back(HDR_FIRST);
                tx_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_queued();
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/psfp_pkg.sv
hw/rtl/psfp_front.sv
hw/rtl/psfp_queue.sv
hw/rtl/psfp_back.sv
hw/rtl/particulate_sensor_frame_parser.sv
sim/psfp_reading_checker.sv
sim/tb_top.sv
